/* hw/rtl/histogram_otsu_threshold_top_assert.svh */
// Assertion macros for the Otsu threshold block.
// Used by histogram_otsu_threshold_top; needs clk and rst_n in scope.
`ifndef HISTOGRAM_OTSU_THRESHOLD_TOP_ASSERT_SVH
`define HISTOGRAM_OTSU_THRESHOLD_TOP_ASSERT_SVH
`ifndef SYNTH
`define HOT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HOT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HOT_ASSERT_SAME(lbl, ante, cons)
`define HOT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hw/rtl/hot_pkg.sv */
// Shared types and constants for the Otsu threshold block.
// No dependencies.
`default_nettype none
package hot_pkg;
    localparam int PIXEL_W         = 8;
    localparam int PIXEL_COUNT_W   = 24;
    localparam int BIN_COUNT_DEF   = 256;
    localparam int COUNT_WIDTH_DEF = 24;
    localparam int QUEUE_DEPTH     = 4;

    typedef struct packed {
        logic [PIXEL_W-1:0] bin;
        logic               last;
    } hot_item_t;
endpackage
`default_nettype wire

/* hw/rtl/hot_front.sv */
// Input side: accepts pixel words, clamps them to a bin and queues them.
// Depends on hot_pkg.
`default_nettype none
module hot_front
    import hot_pkg::*;
#(
    parameter int BIN_COUNT = BIN_COUNT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [PIXEL_W-1:0] pixel,
    input  wire logic               last_pixel,
    input  wire logic               pop,
    output hot_item_t               head,
    output logic                    head_valid,
    input  wire logic               result_done
);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    hot_item_t queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic             last_pending_reg;
    logic             accept;
    logic             do_pop;
    hot_item_t        item_in;

    assign busy       = (count_reg == (PTR_W+1)'(QUEUE_DEPTH)) || last_pending_reg;
    assign accept     = start && !busy;
    assign head_valid = (count_reg != '0);
    assign do_pop     = pop && head_valid;
    assign head       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        item_in.last = last_pixel;
        if ({1'b0, pixel} >= (PIXEL_W+1)'(BIN_COUNT))
        begin
            item_in.bin = PIXEL_W'(BIN_COUNT - 1);
        end
        else
        begin
            item_in.bin = pixel;
        end
        count_next = count_reg + (PTR_W+1)'(accept) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            queue_reg[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
            last_pending_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
            if (accept && last_pixel)
            begin
                last_pending_reg <= 1'b1;
            end
            else if (result_done)
            begin
                last_pending_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/hot_mul.sv */
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on hot_pkg.
`default_nettype none
module hot_mul
    import hot_pkg::*;
#(
    parameter int A_W = 16,
    parameter int B_W = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [A_W-1:0]   a,
    input  wire logic [B_W-1:0]   b,
    output logic                  done,
    output logic [A_W+B_W-1:0]    product
);
    localparam int P_W   = A_W + B_W;
    localparam int CNT_W = $clog2(B_W + 1);

    logic [P_W-1:0]   acc_reg;
    logic [P_W-1:0]   a_reg;
    logic [B_W-1:0]   b_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    assign done    = done_reg;
    assign product = acc_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= P_W'(a);
            b_reg   <= b;
        end
        else if (cnt_reg != '0)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= a_reg << 1;
            b_reg <= b_reg >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (start)
            begin
                cnt_reg  <= CNT_W'(B_W);
                done_reg <= 1'b0;
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg  <= cnt_reg - 1'b1;
                done_reg <= (cnt_reg == CNT_W'(1));
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/hot_back.sv */
// Histogram memory, threshold sweep sequencer and result registers.
// Depends on hot_pkg and hot_mul.
`default_nettype none
module hot_back
    import hot_pkg::*;
#(
    parameter int BIN_COUNT   = BIN_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  hot_item_t                     head,
    input  wire logic                     head_valid,
    output logic                          pop,
    output logic                          done,
    output logic [PIXEL_W-1:0]            threshold,
    output logic [PIXEL_COUNT_W-1:0]      pixel_count,
    output logic                          count_overflow
);
    localparam int BIN_W  = $clog2(BIN_COUNT);
    localparam int N_W    = COUNT_WIDTH + BIN_W;
    localparam int S_W    = COUNT_WIDTH + 2 * BIN_W;
    localparam int D_W    = S_W + N_W;
    localparam int NUM_W  = 2 * D_W;
    localparam int DEN_W  = 2 * N_W;
    localparam int CMP_W  = NUM_W + DEN_W;
    localparam int MA_W   = NUM_W;
    localparam int MB_W   = D_W;
    localparam int TB_W   = BIN_W + COUNT_WIDTH;
    localparam int EXT_W  = COUNT_WIDTH + PIXEL_COUNT_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_UPD  = 4'd1;
    localparam logic [3:0] S_SRD  = 4'd2;
    localparam logic [3:0] S_SACC = 4'd3;
    localparam logic [3:0] S_MP   = 4'd4;
    localparam logic [3:0] S_MQ   = 4'd5;
    localparam logic [3:0] S_MD   = 4'd6;
    localparam logic [3:0] S_MN   = 4'd7;
    localparam logic [3:0] S_ML   = 4'd8;
    localparam logic [3:0] S_MR   = 4'd9;
    localparam logic [3:0] S_CLR  = 4'd10;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [BIN_W-1:0]       T_LAST  = BIN_W'(BIN_COUNT - 1);
    localparam logic [EXT_W-1:0]       PC_LIM  = EXT_W'({PIXEL_COUNT_W{1'b1}});

    logic [COUNT_WIDTH-1:0] bin_mem [BIN_COUNT];
    logic [COUNT_WIDTH-1:0] rdata_reg;
    logic                   mem_we;
    logic [BIN_W-1:0]       mem_wa, mem_ra;
    logic [COUNT_WIDTH-1:0] mem_wd;

    logic [3:0]             state_reg, state_next;
    logic [BIN_W-1:0]       t_reg, t_next;
    logic [BIN_W-1:0]       cur_bin_reg, cur_bin_next;
    logic                   cur_last_reg, cur_last_next;
    logic [COUNT_WIDTH-1:0] total_reg, total_next;
    logic                   ovf_reg, ovf_next;
    logic [N_W-1:0]         n_reg, n_next, nb_reg, nb_next, no_reg, no_next;
    logic [S_W-1:0]         s_reg, s_next, sb_reg, sb_next, so_reg, so_next;
    logic [D_W-1:0]         p_reg, p_next;
    logic [NUM_W-1:0]       num_reg, num_next, best_num_reg, best_num_next;
    logic [DEN_W-1:0]       den_reg, den_next, best_den_reg, best_den_next;
    logic [CMP_W-1:0]       l_reg, l_next;
    logic [BIN_W-1:0]       best_t_reg, best_t_next;
    logic                   done_reg, done_next;
    logic [PIXEL_W-1:0]     threshold_reg, threshold_next;
    logic [PIXEL_COUNT_W-1:0] pixel_count_reg, pixel_count_next;
    logic                   overflow_reg, overflow_next;

    logic                   mul_start, mul_done;
    logic [MA_W-1:0]        mul_a;
    logic [MB_W-1:0]        mul_b;
    logic [MA_W+MB_W-1:0]   mul_p;

    logic [TB_W-1:0]        tb;
    logic [N_W-1:0]         nb_sum, no_diff;
    logic [S_W-1:0]         sb_sum, so_diff;
    logic [D_W-1:0]         q_val, d_val;
    logic [EXT_W-1:0]       total_ext;
    logic                   advance;
    logic                   finish;

    hot_mul #(
        .A_W (MA_W),
        .B_W (MB_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign done           = done_reg;
    assign threshold      = threshold_reg;
    assign pixel_count    = pixel_count_reg;
    assign count_overflow = overflow_reg;

    assign tb      = TB_W'(t_reg) * TB_W'(rdata_reg);
    assign nb_sum  = nb_reg + N_W'(rdata_reg);
    assign sb_sum  = sb_reg + S_W'(tb);
    assign no_diff = n_reg - nb_sum;
    assign so_diff = s_reg - sb_sum;
    assign q_val   = mul_p[D_W-1:0];
    assign d_val   = (p_reg >= q_val) ? (p_reg - q_val) : (q_val - p_reg);
    assign total_ext = EXT_W'(total_reg);

    always_comb
    begin
        state_next       = state_reg;
        t_next           = t_reg;
        cur_bin_next     = cur_bin_reg;
        cur_last_next    = cur_last_reg;
        total_next       = total_reg;
        ovf_next         = ovf_reg;
        n_next           = n_reg;
        s_next           = s_reg;
        nb_next          = nb_reg;
        sb_next          = sb_reg;
        no_next          = no_reg;
        so_next          = so_reg;
        p_next           = p_reg;
        num_next         = num_reg;
        den_next         = den_reg;
        l_next           = l_reg;
        best_num_next    = best_num_reg;
        best_den_next    = best_den_reg;
        best_t_next      = best_t_reg;
        done_next        = 1'b0;
        threshold_next   = threshold_reg;
        pixel_count_next = pixel_count_reg;
        overflow_next    = overflow_reg;
        pop              = 1'b0;
        mem_we           = 1'b0;
        mem_wa           = t_reg;
        mem_wd           = '0;
        mem_ra           = t_reg;
        mul_start        = 1'b0;
        mul_a            = '0;
        mul_b            = '0;
        advance          = 1'b0;
        finish           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                mem_ra = head.bin[BIN_W-1:0];
                if (head_valid)
                begin
                    pop           = 1'b1;
                    cur_bin_next  = head.bin[BIN_W-1:0];
                    cur_last_next = head.last;
                    state_next    = S_UPD;
                end
            end
            S_UPD:
            begin
                mem_wa = cur_bin_reg;
                mem_wd = rdata_reg + 1'b1;
                if (rdata_reg == CNT_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    mem_we = 1'b1;
                    n_next = n_reg + 1'b1;
                    s_next = s_reg + S_W'(cur_bin_reg);
                end
                if (total_reg == CNT_MAX)
                begin
                    ovf_next = 1'b1;
                end
                else
                begin
                    total_next = total_reg + 1'b1;
                end
                if (cur_last_reg)
                begin
                    t_next        = '0;
                    nb_next       = '0;
                    sb_next       = '0;
                    best_num_next = '0;
                    best_den_next = DEN_W'(1);
                    best_t_next   = '0;
                    state_next    = S_SRD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_SRD:
            begin
                state_next = S_SACC;
            end
            S_SACC:
            begin
                nb_next = nb_sum;
                sb_next = sb_sum;
                no_next = no_diff;
                so_next = so_diff;
                if (nb_sum == '0)
                begin
                    advance = 1'b1;
                end
                else if (no_diff == '0)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = MA_W'(sb_sum);
                    mul_b      = MB_W'(no_diff);
                    state_next = S_MP;
                end
            end
            S_MP:
            begin
                if (mul_done)
                begin
                    p_next     = mul_p[D_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = MA_W'(so_reg);
                    mul_b      = MB_W'(nb_reg);
                    state_next = S_MQ;
                end
            end
            S_MQ:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = MA_W'(d_val);
                    mul_b      = d_val;
                    state_next = S_MD;
                end
            end
            S_MD:
            begin
                if (mul_done)
                begin
                    num_next   = mul_p[NUM_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = MA_W'(nb_reg);
                    mul_b      = MB_W'(no_reg);
                    state_next = S_MN;
                end
            end
            S_MN:
            begin
                if (mul_done)
                begin
                    den_next   = mul_p[DEN_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = num_reg;
                    mul_b      = MB_W'(best_den_reg);
                    state_next = S_ML;
                end
            end
            S_ML:
            begin
                if (mul_done)
                begin
                    l_next     = mul_p[CMP_W-1:0];
                    mul_start  = 1'b1;
                    mul_a      = best_num_reg;
                    mul_b      = MB_W'(den_reg);
                    state_next = S_MR;
                end
            end
            S_MR:
            begin
                if (mul_done)
                begin
                    if (l_reg > mul_p[CMP_W-1:0])
                    begin
                        best_num_next = num_reg;
                        best_den_next = den_reg;
                        best_t_next   = t_reg;
                    end
                    advance = 1'b1;
                end
            end
            S_CLR:
            begin
                mem_we = 1'b1;
                mem_wa = t_reg;
                mem_wd = '0;
                t_next = t_reg + 1'b1;
                if (t_reg == T_LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            if (t_reg == T_LAST)
            begin
                finish = 1'b1;
            end
            else
            begin
                t_next     = t_reg + 1'b1;
                state_next = S_SRD;
            end
        end

        if (finish)
        begin
            done_next      = 1'b1;
            threshold_next = PIXEL_W'(best_t_next);
            if (total_ext > PC_LIM)
            begin
                pixel_count_next = {PIXEL_COUNT_W{1'b1}};
            end
            else
            begin
                pixel_count_next = total_ext[PIXEL_COUNT_W-1:0];
            end
            overflow_next = ovf_reg;
            total_next    = '0;
            ovf_next      = 1'b0;
            n_next        = '0;
            s_next        = '0;
            t_next        = '0;
            state_next    = S_CLR;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bin_mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= bin_mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        cur_bin_reg     <= cur_bin_next;
        cur_last_reg    <= cur_last_next;
        nb_reg          <= nb_next;
        sb_reg          <= sb_next;
        no_reg          <= no_next;
        so_reg          <= so_next;
        p_reg           <= p_next;
        num_reg         <= num_next;
        den_reg         <= den_next;
        l_reg           <= l_next;
        best_num_reg    <= best_num_next;
        best_den_reg    <= best_den_next;
        best_t_reg      <= best_t_next;
        threshold_reg   <= threshold_next;
        pixel_count_reg <= pixel_count_next;
        overflow_reg    <= overflow_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            t_reg     <= '0;
            total_reg <= '0;
            ovf_reg   <= 1'b0;
            n_reg     <= '0;
            s_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            t_reg     <= t_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            n_reg     <= n_next;
            s_reg     <= s_next;
            done_reg  <= done_next;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/histogram_otsu_threshold_top.sv */
// Top level of the Otsu threshold block: input queue, histogram and sweep.
// Depends on hot_pkg, hot_front, hot_back and the assertion macro header.
//
// Pixels are taken while busy is low; the input queue absorbs bursts of up to four words and the
// histogram updates each pixel with a memory read, then a write, before it takes the next one from
// the queue. After the word marked last, busy stays high until the result: each threshold takes a
// histogram read and, if both classes hold pixels, six passes of the shared bit-serial multiplier.
// The result is shown with done high for one cycle and cannot be stalled; a clearing pass over all
// BIN_COUNT bins of the histogram memory follows it before queued pixels are counted.
// The same clearing pass runs after reset before the first pixel is counted.
`default_nettype none
`include "histogram_otsu_threshold_top_assert.svh"
module histogram_otsu_threshold_top
    import hot_pkg::*;
#(
    parameter int BIN_COUNT   = BIN_COUNT_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic [PIXEL_W-1:0]       pixel,
    input  wire logic                     last_pixel,
    output logic                          done,
    output logic [PIXEL_W-1:0]            threshold,
    output logic [PIXEL_COUNT_W-1:0]      pixel_count,
    output logic                          count_overflow
);
    hot_item_t head;
    logic      head_valid;
    logic      pop;

    hot_front #(
        .BIN_COUNT (BIN_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pixel       (pixel),
        .last_pixel  (last_pixel),
        .pop         (pop),
        .head        (head),
        .head_valid  (head_valid),
        .result_done (done)
    );

    hot_back #(
        .BIN_COUNT   (BIN_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop),
        .done           (done),
        .threshold      (threshold),
        .pixel_count    (pixel_count),
        .count_overflow (count_overflow)
    );

    `HOT_ASSERT_SAME(a_done_while_busy, done, busy)
    `HOT_ASSERT_NEXT(a_last_sets_busy, start && !busy && last_pixel, busy)
    `HOT_ASSERT_NEXT(a_done_single, done, !done)
endmodule
`default_nettype wire

/* tb/tb_histogram_otsu_threshold_top.sv */
// Testbench for histogram_otsu_threshold_top: sends pixel images and checks each Otsu result.
// Depends on hot_pkg and the block; a scoreboard class predicts threshold, count and flag.
`timescale 1ns / 100ps
`default_nettype none

module tb_histogram_otsu_threshold_top;
    import hot_pkg::*;

    typedef struct {
        logic [PIXEL_W-1:0]       thr;
        logic [PIXEL_COUNT_W-1:0] cnt;
        logic                     ovf;
    } otsu_result_t;

    class otsu_scoreboard;
        logic [COUNT_WIDTH_DEF-1:0] hist[BIN_COUNT_DEF];
        logic [COUNT_WIDTH_DEF-1:0] total;
        logic                       sat_seen;
        otsu_result_t               expected_q[$];
        int                         errors;

        function new();
            errors = 0;
            clear_hist();
        endfunction

        function void clear_hist();
            foreach (hist[i])
                hist[i] = '0;
            total = '0;
            sat_seen = 1'b0;
        endfunction

        function void class_variance(longint unsigned nb, longint unsigned sb,
                                     longint unsigned no, longint unsigned so,
                                     output bit [255:0] num, output bit [255:0] den);
            bit [255:0] p;
            bit [255:0] q;
            bit [255:0] d;
            p = 256'(sb) * 256'(no);
            q = 256'(so) * 256'(nb);
            d = (p >= q) ? p - q : q - p;
            num = d * d;
            den = 256'(nb) * 256'(no);
        endfunction

        function logic [PIXEL_W-1:0] otsu_level();
            longint unsigned n;
            longint unsigned s;
            longint unsigned upper;
            longint unsigned nb;
            longint unsigned sb;
            bit [255:0] best_num;
            bit [255:0] best_den;
            bit [255:0] num;
            bit [255:0] den;
            int best_t;
            n = 0;
            s = 0;
            upper = 0;
            best_t = 0;
            for (int t = 0; t < BIN_COUNT_DEF; t++)
            begin
                n += hist[t];
                s += longint'(t) * hist[t];
                if (t > 0)
                    upper += hist[t];
            end
            if (upper == 0)
                return '0;
            nb = hist[0];
            sb = 0;
            if (nb == 0)
            begin
                best_num = 0;
                best_den = 1;
            end
            else
                class_variance(nb, sb, n - nb, s - sb, best_num, best_den);
            for (int t = 1; t < BIN_COUNT_DEF; t++)
            begin
                nb += hist[t];
                sb += longint'(t) * hist[t];
                if (nb == 0)
                    continue;
                if (n == nb)
                    break;
                class_variance(nb, sb, n - nb, s - sb, num, den);
                if (num * best_den > best_num * den)
                begin
                    best_num = num;
                    best_den = den;
                    best_t = t;
                end
            end
            return PIXEL_W'(best_t);
        endfunction

        function void note_word(logic [PIXEL_W-1:0] px, logic last);
            otsu_result_t r;
            if (&hist[px])
                sat_seen = 1'b1;
            else
                hist[px] = hist[px] + 1'b1;
            if (&total)
                sat_seen = 1'b1;
            else
                total = total + 1'b1;
            if (last)
            begin
                r.thr = otsu_level();
                r.cnt = total;
                r.ovf = sat_seen;
                expected_q.push_back(r);
                clear_hist();
            end
        endfunction

        function void check_word(logic [PIXEL_W-1:0] thr, logic [PIXEL_COUNT_W-1:0] cnt,
                                 logic ovf);
            otsu_result_t r;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected word thr=%0d cnt=%0d ovf=%0b", $time, thr, cnt, ovf);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (thr !== r.thr)
            begin
                $display("%0t: threshold expected %0d actual %0d", $time, r.thr, thr);
                errors++;
            end
            if (cnt !== r.cnt)
            begin
                $display("%0t: pixel_count expected %0d actual %0d", $time, r.cnt, cnt);
                errors++;
            end
            if (ovf !== r.ovf)
            begin
                $display("%0t: count_overflow expected %0b actual %0b", $time, r.ovf, ovf);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [PIXEL_W-1:0]       pixel;
    logic                     last_pixel;
    logic                     done;
    logic [PIXEL_W-1:0]       threshold;
    logic [PIXEL_COUNT_W-1:0] pixel_count;
    logic                     count_overflow;

    otsu_scoreboard sb;
    int             sent;

    histogram_otsu_threshold_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .pixel(pixel),
        .last_pixel(last_pixel),
        .done(done),
        .threshold(threshold),
        .pixel_count(pixel_count),
        .count_overflow(count_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #10 clk = ~clk;
    end

    initial
    begin
        #20s;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_word(threshold, pixel_count, count_overflow);
    end

    task automatic send_word(logic [PIXEL_W-1:0] px, logic last);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        pixel <= px;
        last_pixel <= last;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        sb.note_word(px, last);
        sent++;
    endtask

    task automatic send_image(int npix, int hi);
        for (int i = 0; i < npix; i++)
            send_word(PIXEL_W'($urandom_range(0, hi)), i == npix - 1);
    endtask

    task automatic drain_results();
        @(negedge clk);
        start <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int npix;
        int hi;
        int mode;
        sb = new();
        sent = 0;
        rst_n = 1'b0;
        start = 1'b0;
        pixel = '0;
        last_pixel = 1'b0;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(8'd0, 1'b1);
        send_word(8'd255, 1'b1);
        send_word(8'd0, 1'b0);
        send_word(8'd255, 1'b1);
        send_word(8'd7, 1'b0);
        send_word(8'd7, 1'b1);
        send_word(8'd1, 1'b0);
        send_word(8'd1, 1'b0);
        send_word(8'd3, 1'b0);
        send_word(8'd3, 1'b1);
        send_word(8'd0, 1'b0);
        send_word(8'd0, 1'b0);
        send_word(8'd5, 1'b1);
        send_word(8'd2, 1'b0);
        send_word(8'd4, 1'b0);
        send_word(8'd6, 1'b0);
        send_word(8'd9, 1'b1);
        send_word(8'd170, 1'b0);
        send_word(8'd85, 1'b0);
        send_word(8'd128, 1'b1);
        drain_results();

        while (sent < 1420)
        begin
            mode = $urandom_range(0, 29);
            npix = $urandom_range(1, 45);
            if (mode == 0)
                hi = 255;
            else if (mode < 7)
                hi = 63;
            else
                hi = $urandom_range(1, 15);
            send_image(npix, hi);
            if ($urandom_range(0, 9) == 0)
                drain_results();
        end

        drain_results();
        repeat (300)
            @(posedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

`default_nettype wire
